// ===== hw/rtl/dts_pkg.sv =====
// Shared types, constants and a helper function for the DFS topological sort block.
`default_nettype none

package dts_pkg;

   // Field widths of the transaction payloads
   localparam int unsigned VTX_W     = 4;
   localparam int unsigned ROW_W     = 16;
   localparam int unsigned CFG_W     = 5;
   // Largest graph the 4-bit vertex field can name
   localparam int unsigned VTX_LIMIT = 16;

   typedef logic [VTX_W-1:0] vertex_type;
   typedef logic [ROW_W-1:0] row_type;
   typedef logic [CFG_W-1:0] count_type;

   // Adjacency store write request (one row per input transaction)
   typedef struct packed {
      logic       en;
      vertex_type addr;
      row_type    data;
   } adj_wr_req_type;

   // Adjacency store read request from the search engine
   typedef struct packed {
      logic       en;
      vertex_type addr;
   } adj_rd_req_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_TOP_WAIT,
      ST_EMIT
   } state_type;

   // Index of the lowest set bit; caller guarantees a nonzero word
   function automatic vertex_type lowest_set(input row_type word);
      vertex_type idx;
      idx = '0;
      for (int i = ROW_W - 1; i >= 0; i--) begin
         if (word[i]) begin
            idx = VTX_W'(i);
         end
      end
      return idx;
   endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/dfs_topological_sort_top.sv =====
// Top level of the DFS topological sort block: handshake, vertex count register, trigger decode.
// Operation: the row transaction for vertex n-1 starts a search, which pushes and pops each vertex
//   once, refetches the top vertex's row after every pop that leaves the stack nonempty, and then
//   reads the finished order out of the vertex memory.
// Output: results leave one at a time, each vertex memory read waiting until the previous one
//   reaches a free output register; input is stalled from the trigger until the order is read out.
// Reset (synchronous): controller idle, counters cleared, vertex count 16; memories keep contents.
`default_nettype none

module dfs_topological_sort_top #(
   parameter int unsigned MAX_VERTICES = 16
) (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 req_valid,
   output logic                req_ready,
   input  wire dts_pkg::vertex_type req_row_index,
   input  wire dts_pkg::row_type    req_row_bits,
   output logic                rsp_valid,
   input  wire                 rsp_ready,
   output dts_pkg::vertex_type rsp_vertex,
   output logic                rsp_last,
   input  wire                 csr_wr_en,
   input  wire dts_pkg::count_type  csr_wr_data
);
   import dts_pkg::*;

   localparam int unsigned CAP = (MAX_VERTICES < VTX_LIMIT) ? MAX_VERTICES : VTX_LIMIT;
   localparam count_type   CAP_N = CFG_W'(CAP);

   count_type      vertex_count_ff, vertex_count_in;
   count_type      count_n;
   logic           req_take;
   logic           row_in_store;
   logic           start;
   logic           idle;
   adj_wr_req_type adj_wr_req;
   adj_rd_req_type adj_rd_req;
   row_type        adj_rd_data;

   // Vertex count register
   always_comb begin
      vertex_count_in = vertex_count_ff;
      if (csr_wr_en) begin
         vertex_count_in = csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vertex_count_ff <= CFG_W'(VTX_LIMIT);
      end else begin
         vertex_count_ff <= vertex_count_in;
      end
   end

   // Active graph size, clamped to 1 .. CAP
   always_comb begin
      if (vertex_count_ff == '0) begin
         count_n = CFG_W'(1);
      end else if (vertex_count_ff > CAP_N) begin
         count_n = CAP_N;
      end else begin
         count_n = vertex_count_ff;
      end
   end

   // Row write and search trigger
   assign req_ready    = idle;
   assign req_take     = req_valid && idle;
   assign row_in_store = ({1'b0, req_row_index} < CAP_N);
   assign start        = req_take && row_in_store &&
                         ({1'b0, req_row_index} == (count_n - CFG_W'(1)));

   always_comb begin
      adj_wr_req.en   = req_take && row_in_store;
      adj_wr_req.addr = req_row_index;
      adj_wr_req.data = req_row_bits;
   end

   dts_adj_store #(
      .DEPTH (CAP)
   ) u_adj_store (
      .clock   (clock),
      .wr_req  (adj_wr_req),
      .rd_req  (adj_rd_req),
      .rd_data (adj_rd_data)
   );

   dts_engine #(
      .DEPTH (CAP)
   ) u_engine (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .count_n     (count_n),
      .adj_rd_data (adj_rd_data),
      .adj_rd_req  (adj_rd_req),
      .idle        (idle),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_vertex  (rsp_vertex),
      .rsp_last    (rsp_last)
   );

endmodule

`default_nettype wire

// ===== hw/rtl/dts_adj_store.sv =====
// Adjacency row memory: written by input transactions, read by the search engine.
`default_nettype none

module dts_adj_store #(
   parameter int unsigned DEPTH = 16
) (
   input  wire                      clock,
   input  wire dts_pkg::adj_wr_req_type wr_req,
   input  wire dts_pkg::adj_rd_req_type rd_req,
   output dts_pkg::row_type         rd_data
);
   import dts_pkg::*;

   localparam int unsigned AW = $clog2(DEPTH);

   row_type adj_mem [DEPTH];
   row_type rd_data_ff;

   // One write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_req.en) begin
         adj_mem[wr_req.addr[AW-1:0]] <= wr_req.data;
      end
      if (rd_req.en) begin
         rd_data_ff <= adj_mem[rd_req.addr[AW-1:0]];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/dts_engine.sv =====
// Search sequencer: DFS over the adjacency store, stack and post-order in one memory, emission.
`default_nettype none

module dts_engine #(
   parameter int unsigned DEPTH = 16
) (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  start,
   input  wire dts_pkg::count_type  count_n,
   input  wire dts_pkg::row_type    adj_rd_data,
   output dts_pkg::adj_rd_req_type  adj_rd_req,
   output logic                 idle,
   output logic                 rsp_valid,
   input  wire                  rsp_ready,
   output dts_pkg::vertex_type  rsp_vertex,
   output logic                 rsp_last
);
   import dts_pkg::*;

   localparam int unsigned AW = $clog2(DEPTH);
   localparam int unsigned PW = $clog2(DEPTH + 1);
   localparam logic [PW-1:0] TOP_ADDR = PW'(DEPTH - 1);
   localparam logic [PW-1:0] END_ADDR = PW'(DEPTH);

   // Control and search state
   state_type         state_ff, state_in;
   row_type           visited_ff, visited_in;
   row_type           n_mask_ff, n_mask_in;
   logic [PW-1:0]     depth_ff, depth_in;
   logic [PW-1:0]     post_ff, post_in;
   vertex_type        top_ff, top_in;
   logic              pend_ff, pend_in;
   logic              last_pend_ff, last_pend_in;
   logic              rsp_valid_ff, rsp_valid_in;
   vertex_type        rsp_vertex_ff, rsp_vertex_in;
   logic              rsp_last_ff, rsp_last_in;

   // Vertex memory: stack grows up from entry 0, post-order grows down from the top entry
   vertex_type        vtx_mem [DEPTH];
   vertex_type        vtx_rd_ff;
   logic              vtx_wr_en;
   logic [PW-1:0]     vtx_wr_addr;
   vertex_type        vtx_wr_data;
   logic              vtx_rd_en;
   logic [PW-1:0]     vtx_rd_addr;

   row_type           cand;
   vertex_type        pick;
   logic [PW-1:0]     depth_dec;

   always_ff @(posedge clock) begin
      if (vtx_wr_en) begin
         vtx_mem[vtx_wr_addr[AW-1:0]] <= vtx_wr_data;
      end
      if (vtx_rd_en) begin
         vtx_rd_ff <= vtx_mem[vtx_rd_addr[AW-1:0]];
      end
   end

   // Unvisited candidates: roots when the stack is empty, else neighbors of the top vertex
   always_comb begin
      if (depth_ff == '0) begin
         cand = ~visited_ff & n_mask_ff;
      end else begin
         cand = adj_rd_data & ~visited_ff & n_mask_ff;
      end
      pick      = lowest_set(cand);
      depth_dec = depth_ff - PW'(1);
   end

   // State register and search state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         visited_ff   <= '0;
         depth_ff     <= '0;
         post_ff      <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         visited_ff   <= visited_in;
         depth_ff     <= depth_in;
         post_ff      <= post_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      n_mask_ff     <= n_mask_in;
      top_ff        <= top_in;
      last_pend_ff  <= last_pend_in;
      rsp_vertex_ff <= rsp_vertex_in;
      rsp_last_ff   <= rsp_last_in;
   end

   // Next state, memory accesses
   always_comb begin
      state_in     = state_ff;
      visited_in   = visited_ff;
      n_mask_in    = n_mask_ff;
      depth_in     = depth_ff;
      post_in      = post_ff;
      top_in       = top_ff;
      pend_in      = 1'b0;
      last_pend_in = last_pend_ff;
      vtx_wr_en    = 1'b0;
      vtx_wr_addr  = '0;
      vtx_wr_data  = '0;
      vtx_rd_en    = 1'b0;
      vtx_rd_addr  = '0;
      adj_rd_req   = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               visited_in = '0;
               depth_in   = '0;
               post_in    = '0;
               n_mask_in  = ROW_W'((32'h1 << count_n) - 32'h1);
               state_in   = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (cand != '0) begin
               // Push the chosen vertex and fetch its row
               vtx_wr_en       = 1'b1;
               vtx_wr_addr     = depth_ff;
               vtx_wr_data     = pick;
               depth_in        = depth_ff + PW'(1);
               visited_in      = visited_ff | (ROW_W'(1) << pick);
               top_in          = pick;
               adj_rd_req.en   = 1'b1;
               adj_rd_req.addr = pick;
            end else if (depth_ff == '0) begin
               state_in = ST_EMIT;
            end else begin
               // Top vertex finished: record it and pop
               vtx_wr_en   = 1'b1;
               vtx_wr_addr = TOP_ADDR - post_ff;
               vtx_wr_data = top_ff;
               post_in     = post_ff + PW'(1);
               depth_in    = depth_dec;
               if (depth_dec != '0) begin
                  vtx_rd_en   = 1'b1;
                  vtx_rd_addr = depth_dec - PW'(1);
                  state_in    = ST_TOP_WAIT;
               end
            end
         end
         ST_TOP_WAIT: begin
            top_in          = vtx_rd_ff;
            adj_rd_req.en   = 1'b1;
            adj_rd_req.addr = vtx_rd_ff;
            state_in        = ST_SCAN;
         end
         ST_EMIT: begin
            // Read back latest finished vertex first, once the output slot frees
            if (post_ff != '0) begin
               if (!pend_ff && (!rsp_valid_ff || rsp_ready)) begin
                  vtx_rd_en    = 1'b1;
                  vtx_rd_addr  = END_ADDR - post_ff;
                  post_in      = post_ff - PW'(1);
                  pend_in      = 1'b1;
                  last_pend_in = (post_ff == PW'(1));
               end
            end else if (!pend_ff) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Output register: load from the pending read, clear when taken
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_vertex_in = rsp_vertex_ff;
      rsp_last_in   = rsp_last_ff;
      if (pend_ff) begin
         rsp_valid_in  = 1'b1;
         rsp_vertex_in = vtx_rd_ff;
         rsp_last_in   = last_pend_ff;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign idle       = (state_ff == ST_IDLE);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_vertex = rsp_vertex_ff;
   assign rsp_last   = rsp_last_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/dts_checker.sv =====
// Port-level checker for the DFS topological sort block, with its bind to the top level.
`default_nettype none

module dts_checker (
   input wire                 clock,
   input wire                 reset,
   input wire                 req_ready,
   input wire                 rsp_valid,
   input wire                 rsp_ready,
   input wire dts_pkg::vertex_type rsp_vertex,
   input wire                 rsp_last
);
   import dts_pkg::*;

   // A stalled result transaction holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_vertex) && $stable(rsp_last))
      else $error("result changed while stalled");

   // No new row is taken while a result other than the final one of an order is waiting
   a_busy_mid_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> !req_ready)
      else $error("input ready in the middle of an order");

   // The final result of an order is never followed at once by another
   a_gap_after_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_last |=> !rsp_valid)
      else $error("result right after the final vertex");

   // Coming out of reset: idle and no result pending
   a_reset_state: assert property (@(posedge clock)
      reset |=> req_ready && !rsp_valid)
      else $error("bad state after reset");

endmodule

bind dfs_topological_sort_top dts_checker u_dts_checker (
   .clock         (clock),
   .reset         (reset),
   .req_ready     (req_ready),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_vertex    (rsp_vertex),
   .rsp_last      (rsp_last)
);

`default_nettype wire
